// File: rtl/ght_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_pkg
// Types and constants shared by the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int IDX_W      = 6;
  localparam int LIMIT_W    = 7;
  localparam int GEN_W      = 32;
  localparam int KIND_W     = 8;
  localparam int REFS_W     = 16;
  localparam int RES_W      = 64;
  localparam int RES_WORDS  = 4;
  localparam int PAY_W      = RES_W * RES_WORDS;

  localparam logic [KIND_W-1:0]  TYPE_FIRST = 8'd1;
  localparam logic [KIND_W-1:0]  TYPE_LAST  = 8'd8;
  localparam logic [REFS_W-1:0]  REFS_MAX   = 16'hFFFF;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 7'd64;

  typedef enum logic [1:0] {
    MODE_INSTALL   = 2'd0,
    MODE_RESOLVE   = 2'd1,
    MODE_DUPLICATE = 2'd2,
    MODE_CLOSE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OC_CLOSED   = 2'd0,
    OC_ERROR    = 2'd1,
    OC_RETAINED = 2'd2,
    OC_UNKNOWN  = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_STALE        = 3'd1,
    ST_WRONG_TYPE   = 3'd2,
    ST_BAD_TYPE     = 3'd3,
    ST_FULL         = 3'd4,
    ST_CLOSE_FAILED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_EXEC
  } fsm_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  target;
    logic [GEN_W-1:0]  gen;
  } slot_word_t;

  typedef struct packed {
    logic [REFS_W-1:0] refs;
    logic [KIND_W-1:0] kind;
  } obj_word_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } find_t;

endpackage

// File: rtl/ght_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_in_if
// Input item channel of the handle table.
// ----------------------------------------------------------------------------
interface ght_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] handle_in;
  logic [7:0]  object_type;
  logic [1:0]  close_outcome;
  logic [63:0] resource_word0;
  logic [63:0] resource_word1;
  logic [63:0] resource_word2;
  logic [63:0] resource_word3;

  modport source (output valid, mode, handle_in, object_type, close_outcome,
                  resource_word0, resource_word1, resource_word2, resource_word3,
                  input ready);
  modport sink (input valid, mode, handle_in, object_type, close_outcome,
                resource_word0, resource_word1, resource_word2, resource_word3,
                output ready);
endinterface

// File: rtl/ght_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_out_if
// Result item channel of the handle table.
// ----------------------------------------------------------------------------
interface ght_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] handle_out;
  logic [63:0] resource_out0;
  logic [63:0] resource_out1;
  logic [63:0] resource_out2;
  logic [63:0] resource_out3;

  modport source (output valid, status, handle_out, resource_out0, resource_out1,
                  resource_out2, resource_out3, input ready);
  modport sink (input valid, status, handle_out, resource_out0, resource_out1,
                resource_out2, resource_out3, output ready);
endinterface

// File: rtl/ght_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ght_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_find
// Finds the lowest free entry among the allowed ones.
// ----------------------------------------------------------------------------
module ght_find
  import ght_pkg::*;
(
  input  logic [NUM_SLOTS-1:0] free_mask,
  output find_t                res
);

  always_comb begin
    res = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        res.found = 1'b1;
        res.idx   = IDX_W'(i);
      end
    end
  end

endmodule

// File: rtl/generational_handle_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_table_core
// Typed, generation-checked handle table with reference-counted objects.
//
//   port     dir  kind        contents
//   in_ch    in   valid/ready mode, handle, type, close outcome, 4 words
//   out_ch   out  valid/ready status, handle, 4 resource words
//   cfg_*    in   write       table_limit
//
// Each item passes through accept, slot read, object and second slot
// read, then the write-back, all through the one read port of each RAM.
// The write-back waits while a previous result is still held in the output
// register. Reset leaves the table empty at once; all generations read as one.
// ----------------------------------------------------------------------------
module generational_handle_table_core
  import ght_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  ght_in_if.sink             in_ch,
  ght_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  fsm_t state_r, state_nxt;

  logic [1:0]         mode_r;
  logic [63:0]        h_r;
  logic [KIND_W-1:0]  t_r;
  logic [1:0]         oc_r;
  logic [PAY_W-1:0]   pay_r;
  logic [LIMIT_W-1:0] lim_r;
  logic [NUM_SLOTS-1:0] slot_live_r, obj_live_r, gen_wr_r;
  logic [LIMIT_W-1:0] cnt_r;
  slot_word_t         sq_r, sq_nxt;

  logic               out_valid_r;
  logic [2:0]         status_r;
  logic [63:0]        hout_r;
  logic [PAY_W-1:0]   rout_r;

  logic [NUM_SLOTS-1:0] lim_mask;
  find_t fs, fo;
  logic  lim_ok;

  logic [IDX_W-1:0] sidx, slot_raddr, obj_raddr, tgt;
  slot_word_t slot_rd, slot_wd;
  obj_word_t  obj_rd, obj_wd;
  logic [PAY_W-1:0] pay_rd;
  logic slot_we, obj_we, pay_we;
  logic [IDX_W-1:0] slot_waddr;

  logic in_fire, exec_fire;

  logic [15:0] enc;
  logic [7:0]  ht, rsv;
  logic [31:0] hg, gen_n, gen_inc;
  logic        type_ok_h, type_ok_t, dec_ok, obj_ok;
  logic [REFS_W-1:0] refs_dec;

  logic [2:0]  st_nxt;
  logic [63:0] hout_nxt;
  logic [PAY_W-1:0] rout_nxt;
  logic set_slot, clr_slot, set_obj, clr_obj, cnt_inc, cnt_dec;
  logic [IDX_W-1:0] set_slot_idx;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      lim_mask[i] = (LIMIT_W'(i) < lim_r);
    end
  end

  assign lim_ok = (lim_r >= 7'd1) && (lim_r <= LIMIT_W'(NUM_SLOTS));

  ght_find u_find_slot (.free_mask(~slot_live_r & lim_mask), .res(fs));
  ght_find u_find_obj  (.free_mask(~obj_live_r & lim_mask), .res(fo));

  assign enc  = h_r[15:0];
  assign ht   = h_r[23:16];
  assign rsv  = h_r[31:24];
  assign hg   = h_r[63:32];
  assign sidx = IDX_W'(enc[IDX_W-1:0] - 6'd1);

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  always_comb begin
    slot_raddr = fs.idx;
    if (state_r == S_RD1 && mode_r != MODE_INSTALL) begin
      slot_raddr = sidx;
    end
    obj_raddr = (state_r == S_RD2) ? slot_rd.target : sq_r.target;
    if (mode_r == MODE_INSTALL) begin
      obj_raddr = fo.idx;
    end
  end

  ght_ram #(.WIDTH($bits(slot_word_t)), .DEPTH(NUM_SLOTS)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wd),
    .raddr(slot_raddr), .rdata(slot_rd)
  );
  ght_ram #(.WIDTH($bits(obj_word_t)), .DEPTH(NUM_SLOTS)) u_obj_ram (
    .clk(clk), .we(obj_we), .waddr(tgt), .wdata(obj_wd),
    .raddr(obj_raddr), .rdata(obj_rd)
  );
  ght_ram #(.WIDTH(PAY_W), .DEPTH(NUM_SLOTS)) u_pay_ram (
    .clk(clk), .we(pay_we), .waddr(tgt), .wdata(pay_r),
    .raddr(obj_raddr), .rdata(pay_rd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_RD1;
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_EXEC;
      S_EXEC: if (exec_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    sq_nxt = slot_rd;
    if (!gen_wr_r[(mode_r == MODE_INSTALL) ? fs.idx : sidx]) begin
      sq_nxt.gen = 32'd1;
    end
  end

  always_comb begin
    tgt       = (mode_r == MODE_INSTALL) ? fo.idx : sq_r.target;
    gen_n     = gen_wr_r[fs.idx] ? slot_rd.gen : 32'd1;
    gen_inc   = (sq_r.gen == 32'hFFFF_FFFF) ? 32'd1 : sq_r.gen + 32'd1;
    refs_dec  = obj_rd.refs - 16'd1;
    type_ok_h = (ht >= TYPE_FIRST) && (ht <= TYPE_LAST);
    type_ok_t = (t_r >= TYPE_FIRST) && (t_r <= TYPE_LAST);
    dec_ok    = lim_ok && (h_r != 64'd0) && (enc != 16'd0) &&
                (enc <= 16'(lim_r)) && (rsv == 8'd0) && (hg != 32'd0) &&
                type_ok_h && slot_live_r[sidx] && (sq_r.gen == hg) &&
                (sq_r.kind == ht);
    obj_ok    = (LIMIT_W'(sq_r.target) < lim_r) && obj_live_r[sq_r.target] &&
                (obj_rd.refs != 16'd0) && (obj_rd.kind == sq_r.kind);

    st_nxt = ST_OK;
    hout_nxt = '0;
    rout_nxt = '0;
    slot_we = 1'b0;
    obj_we = 1'b0;
    pay_we = 1'b0;
    slot_waddr = sidx;
    slot_wd = '{kind: '0, target: '0, gen: gen_inc};
    obj_wd = '{refs: refs_dec, kind: (refs_dec == 16'd0) ? 8'd0 : obj_rd.kind};
    set_slot = 1'b0;
    clr_slot = 1'b0;
    set_obj = 1'b0;
    clr_obj = 1'b0;
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    set_slot_idx = fs.idx;

    case (mode_r)
      MODE_INSTALL: begin
        if (!type_ok_t) begin
          st_nxt = ST_BAD_TYPE;
        end else if (!lim_ok || !fs.found || !fo.found) begin
          st_nxt = ST_FULL;
        end else begin
          pay_we = 1'b1;
          obj_we = 1'b1;
          obj_wd = '{refs: 16'd1, kind: t_r};
          slot_we = 1'b1;
          slot_waddr = fs.idx;
          slot_wd = '{kind: t_r, target: fo.idx, gen: sq_r.gen};
          set_slot = 1'b1;
          set_obj = 1'b1;
          cnt_inc = 1'b1;
          hout_nxt = {sq_r.gen, 8'd0, t_r, 16'(fs.idx) + 16'd1};
        end
      end
      MODE_RESOLVE: begin
        if (!dec_ok) begin
          st_nxt = ST_STALE;
        end else if (t_r != 8'd0 && sq_r.kind != t_r) begin
          st_nxt = ST_WRONG_TYPE;
        end else if (!obj_ok) begin
          st_nxt = ST_STALE;
        end else begin
          rout_nxt = pay_rd;
        end
      end
      MODE_DUPLICATE: begin
        if (!dec_ok) begin
          st_nxt = ST_STALE;
        end else if (!fs.found || cnt_r >= lim_r) begin
          st_nxt = ST_FULL;
        end else if (!obj_live_r[sq_r.target] || obj_rd.refs == REFS_MAX) begin
          st_nxt = ST_STALE;
        end else begin
          obj_we = 1'b1;
          obj_wd = '{refs: obj_rd.refs + 16'd1, kind: obj_rd.kind};
          slot_we = 1'b1;
          slot_waddr = fs.idx;
          slot_wd = '{kind: sq_r.kind, target: sq_r.target, gen: gen_n};
          set_slot = 1'b1;
          cnt_inc = 1'b1;
          hout_nxt = {gen_n, 8'd0, sq_r.kind, 16'(fs.idx) + 16'd1};
        end
      end
      default: begin
        if (!dec_ok || !obj_ok) begin
          st_nxt = ST_STALE;
        end else if (obj_rd.refs <= 16'd1 &&
                     (oc_r == OC_RETAINED || oc_r == OC_UNKNOWN)) begin
          st_nxt = ST_CLOSE_FAILED;
        end else begin
          slot_we = 1'b1;
          obj_we = 1'b1;
          clr_slot = 1'b1;
          cnt_dec = 1'b1;
          clr_obj = (refs_dec == 16'd0);
          set_slot_idx = sidx;
          if (obj_rd.refs <= 16'd1 && oc_r == OC_ERROR) begin
            st_nxt = ST_CLOSE_FAILED;
          end
        end
      end
    endcase

    if (!exec_fire) begin
      slot_we = 1'b0;
      obj_we = 1'b0;
      pay_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lim_r       <= LIMIT_RST;
      slot_live_r <= '0;
      obj_live_r  <= '0;
      gen_wr_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        lim_r <= cfg_wdata;
      end
      if (exec_fire) begin
        out_valid_r <= 1'b1;
        if (set_slot) begin
          slot_live_r[set_slot_idx] <= 1'b1;
          gen_wr_r[set_slot_idx]    <= 1'b1;
        end
        if (clr_slot) begin
          slot_live_r[set_slot_idx] <= 1'b0;
          gen_wr_r[set_slot_idx]    <= 1'b1;
        end
        if (set_obj) begin
          obj_live_r[tgt] <= 1'b1;
        end
        if (clr_obj) begin
          obj_live_r[tgt] <= 1'b0;
        end
        if (cnt_inc) begin
          cnt_r <= cnt_r + 7'd1;
        end else if (cnt_dec) begin
          cnt_r <= cnt_r - 7'd1;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_ch.mode;
      h_r    <= in_ch.handle_in;
      t_r    <= in_ch.object_type;
      oc_r   <= in_ch.close_outcome;
      pay_r  <= {in_ch.resource_word3, in_ch.resource_word2,
                 in_ch.resource_word1, in_ch.resource_word0};
    end
    if (state_r == S_RD2) begin
      sq_r <= sq_nxt;
    end
    if (exec_fire) begin
      status_r <= st_nxt;
      hout_r   <= hout_nxt;
      rout_r   <= rout_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.handle_out    = hout_r;
  assign out_ch.resource_out0 = rout_r[63:0];
  assign out_ch.resource_out1 = rout_r[127:64];
  assign out_ch.resource_out2 = rout_r[191:128];
  assign out_ch.resource_out3 = rout_r[255:192];

  a_cnt_matches_live: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_live_r) == 32'(cnt_r))
    else $error("live handle count disagrees with live slots");

  a_obj_le_slots: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(obj_live_r) <= $countones(slot_live_r))
    else $error("more live objects than live slots");

  a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    slot_we |-> slot_wd.gen != 32'd0)
    else $error("slot generation written as zero");

  a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid_r && state_r == S_IDLE)
    else $error("result not posted after write-back");

endmodule

// File: sim/tb_generational_handle_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_generational_handle_table_core
// Self-checking testbench for the generational handle table core.
//
// Items are sent in bursts, with gaps in most phases, while the result side
// stalls on a pattern of its own in most phases. Each accepted item is run through a behavioral copy
// of the table, and its result is queued and compared field by field with
// the block's output. Directed cases come first, then random traffic under
// several table limits, including a long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_generational_handle_table_core;
  import ght_pkg::*;

  typedef struct packed {
    mode_t                 mode;
    logic [63:0]           handle;
    logic [7:0]            otype;
    outcome_t              outcome;
    logic [3:0][63:0]      words;
  } op_t;

  typedef struct packed {
    status_t               status;
    logic [63:0]           handle;
    logic [3:0][63:0]      res;
  } reply_t;

  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  ght_in_if  in_ch ();
  ght_out_if out_ch ();

  generational_handle_table_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table.
  logic [6:0]            lim;
  logic                  sh_slot_live [NUM_SLOTS];
  logic [7:0]            sh_slot_kind [NUM_SLOTS];
  logic [5:0]            sh_slot_target [NUM_SLOTS];
  logic [31:0]           sh_slot_gen [NUM_SLOTS];
  logic                  sh_obj_live [NUM_SLOTS];
  logic [15:0]           sh_obj_refs [NUM_SLOTS];
  logic [7:0]            sh_obj_kind [NUM_SLOTS];
  logic [3:0][63:0]      sh_obj_pay [NUM_SLOTS];
  logic [6:0]            handles_live;
  logic [6:0]            objects_live;

  reply_t      pending_replies[$];
  logic [63:0] stale_pool[$];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  int          rx_style = 1;
  int          hold_cycles = 0;

  function automatic logic [63:0] pack_handle(int idx, logic [7:0] t, logic [31:0] g);
    return {g, 8'h00, t, 16'(idx + 1)};
  endfunction

  function automatic bit kind_ok(logic [7:0] t);
    return t >= TYPE_FIRST && t <= TYPE_LAST;
  endfunction

  function automatic bit limit_ok();
    return lim >= 1 && lim <= NUM_SLOTS;
  endfunction

  function automatic int lookup_slot(logic [63:0] h);
    int i;
    if (!limit_ok() || h == 64'd0 || h[15:0] == 16'd0 || h[15:0] > lim ||
        h[31:24] != 8'd0 || h[63:32] == 32'd0 || !kind_ok(h[23:16]))
      return -1;
    i = h[15:0] - 1;
    if (!sh_slot_live[i] || sh_slot_gen[i] != h[63:32] || sh_slot_kind[i] != h[23:16])
      return -1;
    return i;
  endfunction

  function automatic bit target_ok(int s);
    int o;
    o = sh_slot_target[s];
    if (o >= lim) return 1'b0;
    return sh_obj_live[o] && sh_obj_refs[o] != 16'd0 && sh_obj_kind[o] == sh_slot_kind[s];
  endfunction

  function automatic void close_slot(int s);
    int o;
    o = sh_slot_target[s];
    stale_pool.push_back(pack_handle(s, sh_slot_kind[s], sh_slot_gen[s]));
    if (stale_pool.size() > 16) void'(stale_pool.pop_front());
    sh_slot_live[s] = 1'b0;
    sh_slot_kind[s] = '0;
    sh_slot_target[s] = '0;
    sh_slot_gen[s] = sh_slot_gen[s] + 1;
    if (sh_slot_gen[s] == 32'd0) sh_slot_gen[s] = 32'd1;
    handles_live = handles_live - 1;
    sh_obj_refs[o] = sh_obj_refs[o] - 1;
    if (sh_obj_refs[o] == 16'd0) begin
      sh_obj_live[o] = 1'b0;
      sh_obj_kind[o] = '0;
      sh_obj_pay[o] = '0;
      objects_live = objects_live - 1;
    end
  endfunction

  function automatic reply_t apply_op(op_t op);
    reply_t r;
    int s, o, n, w;
    r = '0;
    r.status = ST_OK;
    if (op.mode == MODE_INSTALL) begin
      if (!kind_ok(op.otype)) begin
        r.status = ST_BAD_TYPE;
      end else begin
        s = -1;
        o = -1;
        if (limit_ok()) begin
          for (w = 0; w < lim; w++) begin
            if (!sh_slot_live[w] && s < 0) s = w;
            if (!sh_obj_live[w] && o < 0) o = w;
          end
        end
        if (s < 0 || o < 0) begin
          r.status = ST_FULL;
        end else begin
          sh_obj_pay[o] = op.words;
          sh_obj_refs[o] = 16'd1;
          sh_obj_kind[o] = op.otype;
          sh_obj_live[o] = 1'b1;
          sh_slot_target[s] = 6'(o);
          sh_slot_kind[s] = op.otype;
          sh_slot_live[s] = 1'b1;
          handles_live = handles_live + 1;
          objects_live = objects_live + 1;
          r.handle = pack_handle(s, op.otype, sh_slot_gen[s]);
        end
      end
    end else begin
      s = lookup_slot(op.handle);
      if (s < 0) begin
        r.status = ST_STALE;
      end else if (op.mode == MODE_RESOLVE) begin
        if (op.otype != 8'd0 && sh_slot_kind[s] != op.otype) r.status = ST_WRONG_TYPE;
        else if (!target_ok(s)) r.status = ST_STALE;
        else r.res = sh_obj_pay[sh_slot_target[s]];
      end else if (op.mode == MODE_DUPLICATE) begin
        n = -1;
        for (w = 0; w < lim && w < NUM_SLOTS; w++)
          if (!sh_slot_live[w] && n < 0) n = w;
        o = sh_slot_target[s];
        if (n < 0 || handles_live >= lim) begin
          r.status = ST_FULL;
        end else if (!sh_obj_live[o] || sh_obj_refs[o] == REFS_MAX) begin
          r.status = ST_STALE;
        end else begin
          sh_obj_refs[o] = sh_obj_refs[o] + 1;
          sh_slot_target[n] = 6'(o);
          sh_slot_kind[n] = sh_slot_kind[s];
          sh_slot_live[n] = 1'b1;
          handles_live = handles_live + 1;
          r.handle = pack_handle(n, sh_slot_kind[s], sh_slot_gen[n]);
        end
      end else begin
        if (!target_ok(s)) begin
          r.status = ST_STALE;
        end else if (sh_obj_refs[sh_slot_target[s]] > 16'd1) begin
          close_slot(s);
        end else if (op.outcome == OC_RETAINED || op.outcome == OC_UNKNOWN) begin
          r.status = ST_CLOSE_FAILED;
        end else begin
          close_slot(s);
          if (op.outcome == OC_ERROR) r.status = ST_CLOSE_FAILED;
        end
      end
    end
    return r;
  endfunction

  task automatic send_op(input op_t op, output reply_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.mode <= op.mode;
    in_ch.handle_in <= op.handle;
    in_ch.object_type <= op.otype;
    in_ch.close_outcome <= op.outcome;
    in_ch.resource_word0 <= op.words[0];
    in_ch.resource_word1 <= op.words[1];
    in_ch.resource_word2 <= op.words[2];
    in_ch.resource_word3 <= op.words[3];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = apply_op(op);
    pending_replies.push_back(r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limit(input logic [6:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    lim = v;
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_live();
    int live_idx[$];
    int i;
    for (i = 0; i < NUM_SLOTS; i++)
      if (sh_slot_live[i]) live_idx.push_back(i);
    if (live_idx.size() == 0) return random_word();
    i = live_idx[$urandom_range(0, live_idx.size() - 1)];
    return pack_handle(i, sh_slot_kind[i], sh_slot_gen[i]);
  endfunction

  function automatic op_t random_op();
    op_t op;
    int sel, w;
    op.mode = mode_t'($urandom_range(0, 3));
    sel = $urandom_range(0, 99);
    if (sel < 72) op.handle = pick_live();
    else if (sel < 82 && stale_pool.size() != 0)
      op.handle = stale_pool[$urandom_range(0, stale_pool.size() - 1)];
    else if (sel < 92) op.handle = pick_live() ^ (64'd1 << $urandom_range(0, 63));
    else op.handle = random_word();
    sel = $urandom_range(0, 99);
    if (op.mode == MODE_RESOLVE && sel < 40) op.otype = 8'd0;
    else if (op.mode == MODE_RESOLVE && sel < 70) op.otype = op.handle[23:16];
    else if (sel < 90) op.otype = 8'($urandom_range(1, 8));
    else op.otype = 8'($urandom_range(0, 255));
    op.outcome = outcome_t'($urandom_range(0, 3));
    for (w = 0; w < 4; w++) op.words[w] = random_word();
    return op;
  endfunction

  function automatic op_t make_op(mode_t m, logic [63:0] h, logic [7:0] t, outcome_t oc);
    op_t op;
    op.mode = m;
    op.handle = h;
    op.otype = t;
    op.outcome = oc;
    op.words = {random_word(), random_word(), random_word(), random_word()};
    return op;
  endfunction

  task automatic test_directed();
    op_t op;
    reply_t r;
    logic [63:0] ha, hb, hd;
    set_limit(7'd64);
    send_op(make_op(MODE_INSTALL, '0, 8'd0, OC_CLOSED), r);
    send_op(make_op(MODE_INSTALL, '0, 8'd9, OC_CLOSED), r);
    send_op(make_op(MODE_INSTALL, '0, 8'd255, OC_CLOSED), r);
    op = make_op(MODE_INSTALL, '1, TYPE_FIRST, OC_CLOSED);
    op.words = '1;
    send_op(op, r);
    ha = r.handle;
    op = make_op(MODE_INSTALL, '0, TYPE_LAST, OC_CLOSED);
    op.words = '0;
    send_op(op, r);
    hb = r.handle;
    send_op(make_op(MODE_RESOLVE, ha, 8'd0, OC_CLOSED), r);
    send_op(make_op(MODE_RESOLVE, ha, TYPE_FIRST, OC_CLOSED), r);
    send_op(make_op(MODE_RESOLVE, ha, 8'd5, OC_CLOSED), r);
    send_op(make_op(MODE_RESOLVE, 64'd0, 8'd0, OC_CLOSED), r);
    send_op(make_op(MODE_RESOLVE, ha | 64'h0000_0000_0100_0000, 8'd0, OC_CLOSED), r);
    send_op(make_op(MODE_RESOLVE, {32'd0, ha[31:0]}, 8'd0, OC_CLOSED), r);
    send_op(make_op(MODE_RESOLVE, {ha[63:16], 16'd0}, 8'd0, OC_CLOSED), r);
    send_op(make_op(MODE_RESOLVE, {ha[63:16], 16'd65}, 8'd0, OC_CLOSED), r);
    send_op(make_op(MODE_RESOLVE, {ha[63:16], 16'hFFFF}, 8'd0, OC_CLOSED), r);
    send_op(make_op(MODE_DUPLICATE, ha, 8'd0, OC_CLOSED), r);
    hd = r.handle;
    send_op(make_op(MODE_CLOSE, hd, 8'd0, OC_UNKNOWN), r);
    send_op(make_op(MODE_RESOLVE, hd, 8'd0, OC_CLOSED), r);
    send_op(make_op(MODE_CLOSE, ha, 8'd0, OC_RETAINED), r);
    send_op(make_op(MODE_CLOSE, ha, 8'd0, OC_UNKNOWN), r);
    send_op(make_op(MODE_CLOSE, ha, 8'd0, OC_ERROR), r);
    send_op(make_op(MODE_CLOSE, hb, 8'd0, OC_CLOSED), r);
    send_op(make_op(MODE_RESOLVE, hb, 8'd0, OC_CLOSED), r);
    send_op(make_op(MODE_DUPLICATE, hb, 8'd0, OC_CLOSED), r);
    send_op(make_op(MODE_CLOSE, ha, 8'd0, OC_CLOSED), r);
  endtask

  task automatic test_random_traffic(input logic [6:0] v, input int n, input int style);
    reply_t r;
    int k;
    set_limit(v);
    rx_style = style;
    gaps_on = (style != 0);
    for (k = 0; k < n; k++) send_op(random_op(), r);
    gaps_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    reply_t r;
    int k;
    drain();
    hold_cycles = 300;
    gaps_on = 1'b0;
    for (k = 0; k < 40; k++) send_op(random_op(), r);
    gaps_on = 1'b1;
    drain();
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_style)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= ($urandom_range(0, 99) < 65);
        end
        default: begin
          out_ch.ready <= (cycles % 7 < 4);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    reply_t want;
    logic [3:0][63:0] got;
    int w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.resource_out3, out_ch.resource_out2, out_ch.resource_out1,
             out_ch.resource_out0};
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $realtime, out_ch.status);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                   out_ch.status);
          errors++;
        end
        if (out_ch.handle_out !== want.handle) begin
          $display("%0t: handle expected %h actual %h", $realtime, want.handle,
                   out_ch.handle_out);
          errors++;
        end
        for (w = 0; w < 4; w++)
          if (got[w] !== want.res[w]) begin
            $display("%0t: resource word %0d expected %h actual %h", $realtime, w,
                     want.res[w], got[w]);
            errors++;
          end
      end
    end
  end

  initial begin
    int i;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_INSTALL;
    in_ch.handle_in = '0;
    in_ch.object_type = '0;
    in_ch.close_outcome = OC_CLOSED;
    in_ch.resource_word0 = '0;
    in_ch.resource_word1 = '0;
    in_ch.resource_word2 = '0;
    in_ch.resource_word3 = '0;
    out_ch.ready = 1'b0;
    lim = LIMIT_RST;
    for (i = 0; i < NUM_SLOTS; i++) begin
      sh_slot_live[i] = 1'b0;
      sh_slot_kind[i] = '0;
      sh_slot_target[i] = '0;
      sh_slot_gen[i] = 32'd1;
      sh_obj_live[i] = 1'b0;
      sh_obj_refs[i] = '0;
      sh_obj_kind[i] = '0;
      sh_obj_pay[i] = '0;
    end
    handles_live = '0;
    objects_live = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(7'd64, 280, 1);
    test_random_traffic(7'd8, 220, 2);
    test_output_backpressure();
    test_random_traffic(7'd1, 100, 1);
    test_random_traffic(7'd33, 220, 0);
    test_random_traffic(7'd64, 200, 1);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
